/* rtl/bpo_pkg.sv */
// Package for the box pair overlap block: default coordinate and ratio
// fraction widths used as parameter defaults. No dependencies.
`default_nettype none
package bpo_pkg;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 16;
endpackage
`default_nettype wire

/* rtl/box_pair_overlap_iou.sv */
// Top level of the box pair overlap block: front, queue, back.
// Uses bpo_pkg, bpo_front, bpo_queue and bpo_back.
`default_nettype none
// Accepts one box pair per cycle while full is low and returns one result per
// pair, in order. Between the edge that accepted a pair and its result at the
// output ports lie 2 front stages, 1 queue stage and RATIO_FRAC_BITS+2 divider
// stages, the first front stage loaded at the accepting edge. The
// one-bit-per-stage restoring divider sets that depth. Full only rises when
// results back up.
module box_pair_overlap_iou #(
  parameter int unsigned COORD_BITS      = bpo_pkg::CoordBitsDef,
  parameter int unsigned RATIO_FRAC_BITS = bpo_pkg::FracBitsDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [COORD_BITS-1:0] a_left, a_top, a_right, a_bottom,
  input  wire logic [COORD_BITS-1:0] b_left, b_top, b_right, b_bottom,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       a_holds_b,
  output logic                       b_holds_a,
  output logic                       partial_overlap,
  output logic [RATIO_FRAC_BITS:0]   overlap_ratio,
  output logic                       degenerate
);
  import bpo_pkg::*;
  localparam int unsigned AW = 2 * COORD_BITS;
  localparam int unsigned QW = 5 + AW + AW + 1;

  logic f_v, f_r, q_v, q_r, o_v, in_r;
  logic ahb, bha, part, dg, zr;
  logic [AW-1:0] inter;
  logic [AW:0] uni;
  logic [QW-1:0] qd;
  logic [3:0] ofl;

  assign full = !in_r;

  bpo_front #(.CoordBits(COORD_BITS)) u_front (
    .clk, .rst, .in_valid(push), .in_ready(in_r),
    .al(a_left), .at(a_top), .ar(a_right), .ab(a_bottom),
    .bl(b_left), .bt(b_top), .br(b_right), .bb(b_bottom),
    .out_valid(f_v), .out_ready(f_r),
    .f_a_holds_b(ahb), .f_b_holds_a(bha), .f_partial(part),
    .f_degen(dg), .f_zero(zr), .f_inter(inter), .f_union(uni));

  bpo_queue #(.W(QW)) u_queue (
    .clk, .rst, .in_valid(f_v), .in_ready(f_r),
    .in_data({ahb, bha, part, dg, zr, inter, uni}),
    .out_valid(q_v), .out_ready(q_r), .out_data(qd));

  bpo_back #(.CoordBits(COORD_BITS), .FracBits(RATIO_FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(q_v), .in_ready(q_r),
    .in_flags(qd[QW-1:QW-4]), .in_zero(qd[QW-5]),
    .in_inter(qd[QW-6 -: AW]), .in_union(qd[AW:0]),
    .out_valid(o_v), .out_ready(pop), .out_flags(ofl),
    .out_ratio(overlap_ratio));

  assign empty           = !o_v;
  assign a_holds_b       = ofl[3];
  assign b_holds_a       = ofl[2];
  assign partial_overlap = ofl[1];
  assign degenerate      = ofl[0];
endmodule
`default_nettype wire

/* rtl/bpo_front.sv */
// Front part: accepts a box pair, forms containment flags, the degenerate
// and empty tests, and the three areas. Uses bpo_pkg.
`default_nettype none
module bpo_front #(
  parameter int unsigned CoordBits = bpo_pkg::CoordBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CoordBits-1:0]   al, at, ar, ab, bl, bt, br, bb,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        f_a_holds_b,
  output logic                        f_b_holds_a,
  output logic                        f_partial,
  output logic                        f_degen,
  output logic                        f_zero,
  output logic [2*CoordBits-1:0]      f_inter,
  output logic [2*CoordBits:0]        f_union
);
  import bpo_pkg::*;
  localparam int unsigned AW = 2 * CoordBits;

  // Stage one: clipped extents and flags.
  logic               s1_valid, s1_ahb, s1_bha, s1_part, s1_inv, s1_empty;
  logic [CoordBits-1:0] s1_iw, s1_ih, s1_aw, s1_ah, s1_bw, s1_bh;
  logic               s2_valid;
  logic               adv1, adv2;

  assign adv2     = !s2_valid || out_ready;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  logic [CoordBits-1:0] il, it, ir, ib;
  logic                 bina, ainb, touch;
  always_comb begin
    il = (al > bl) ? al : bl;
    it = (at > bt) ? at : bt;
    ir = (ar < br) ? ar : br;
    ib = (ab < bb) ? ab : bb;
    bina = (bl >= al) && (br <= ar) && (bt >= at) && (bb <= ab);
    ainb = (al >= bl) && (ar <= br) && (at >= bt) && (ab <= bb);
    touch = !((al > br) || (ar < bl) || (at > bb) || (ab < bt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
    if (adv1) begin
      s1_ahb  <= bina;
      s1_bha  <= ainb;
      s1_part <= !bina && !ainb && touch;
      s1_inv  <= (ar < al) || (ab < at) || (br < bl) || (bb < bt);
      s1_empty <= (ir < il) || (ib < it);
      s1_iw <= ir - il;
      s1_ih <= ib - it;
      s1_aw <= ar - al;
      s1_ah <= ab - at;
      s1_bw <= br - bl;
      s1_bh <= bb - bt;
    end
  end

  // Stage two: three area products and the union.
  logic [AW-1:0] p_i, p_a, p_b;
  logic [AW:0]   uni;
  always_comb begin
    p_i = AW'(s1_iw) * AW'(s1_ih);
    p_a = AW'(s1_aw) * AW'(s1_ah);
    p_b = AW'(s1_bw) * AW'(s1_bh);
    uni = {1'b0, p_a - p_i} + {1'b0, p_b};
  end

  logic [AW-1:0] r_a, r_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2) begin
      f_a_holds_b <= s1_ahb;
      f_b_holds_a <= s1_bha;
      f_partial   <= s1_part;
      f_degen     <= s1_inv;
      f_zero      <= s1_inv || s1_empty;
      f_inter     <= p_i;
      r_a         <= p_a;
      r_b         <= p_b;
    end
  end

  // The union is an add after registered products.
  assign f_union = {1'b0, r_a - f_inter} + {1'b0, r_b};
  assign out_valid = s2_valid;
endmodule
`default_nettype wire

/* rtl/bpo_queue.sv */
// Two-entry queue that decouples front and back; carries one packed
// classified pair per beat. Uses bpo_pkg.
`default_nettype none
module bpo_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);
  import bpo_pkg::*;
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;
  logic         wr, rd;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem[wp] <= in_data;
  end
endmodule
`default_nettype wire

/* rtl/bpo_back.sv */
// Back part: an entry register and a pipelined restoring divider, one
// quotient bit per stage. Uses bpo_pkg.
`default_nettype none
module bpo_back #(
  parameter int unsigned CoordBits = bpo_pkg::CoordBitsDef,
  parameter int unsigned FracBits  = bpo_pkg::FracBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [3:0]          in_flags,
  input  wire logic                in_zero,
  input  wire logic [2*CoordBits-1:0] in_inter,
  input  wire logic [2*CoordBits:0]   in_union,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               out_flags,
  output logic [FracBits:0]        out_ratio
);
  import bpo_pkg::*;
  localparam int unsigned UW = 2 * CoordBits + 1;
  localparam int unsigned NS = FracBits + 1;

  logic              v   [NS+1];
  logic [3:0]        fl  [NS+1];
  logic [UW:0]       rem [NS+1];
  logic [UW-1:0]     den [NS+1];
  logic [FracBits:0] q   [NS+1];
  logic              adv [NS+1];

  // Each stage moves when it is empty or the next one moves; bubbles fill even while the tail waits.
  always_comb begin
    adv[NS] = !v[NS] || out_ready;
    for (int k = NS - 1; k >= 0; k--) adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  // Entry: degenerate zero union becomes a degenerate result.
  logic zu;
  assign zu = !in_zero && (in_union == '0);
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (adv[0]) v[0] <= in_valid;
    if (adv[0]) begin
      fl[0]  <= {in_flags[3:1], in_flags[0] | zu};
      rem[0] <= (in_zero || zu) ? '0 : (UW+1)'(in_inter);
      den[0] <= in_union;
      q[0]   <= '0;
    end
  end

  // One quotient bit per stage; first stage tests without a shift.
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [UW:0] sh;
    logic        ge;
    assign sh = (k == 0) ? rem[k] : {rem[k][UW-1:0], 1'b0};
    assign ge = (den[k] != '0) && (sh >= {1'b0, den[k]});
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (adv[k+1]) v[k+1] <= v[k];
      if (adv[k+1]) begin
        fl[k+1]  <= fl[k];
        den[k+1] <= den[k];
        rem[k+1] <= ge ? sh - {1'b0, den[k]} : sh;
        q[k+1]   <= {q[k][FracBits-1:0], ge};
      end
    end
  end

  assign out_valid = v[NS];
  assign out_flags = fl[NS];
  assign out_ratio = q[NS];
endmodule
`default_nettype wire

/* rtl/bpo_checker.sv */
// Port-level checker for box_pair_overlap_iou and its bind statement.
// Depends on bpo_pkg and the top level's ports.
`default_nettype none
module bpo_checker #(
  parameter int unsigned RATIO_FRAC_BITS = bpo_pkg::FracBitsDef
) (
  input wire logic clk, rst, full, empty, pop,
  input wire logic a_holds_b, b_holds_a, partial_overlap, degenerate,
  input wire logic [RATIO_FRAC_BITS:0] overlap_ratio
);
  // A degenerate result carries a zero ratio.
  a_dg: assert property (@(posedge clk) disable iff (rst)
    !empty && degenerate |-> overlap_ratio == '0) else $error("ratio on degenerate");
  // Partial overlap excludes containment.
  a_pt: assert property (@(posedge clk) disable iff (rst)
    !empty && partial_overlap |-> !a_holds_b && !b_holds_a) else $error("partial");
  // Ratio never exceeds one.
  a_rt: assert property (@(posedge clk) disable iff (rst)
    !empty |-> overlap_ratio <= (1 << RATIO_FRAC_BITS)) else $error("ratio range");
  // A waiting result holds while not taken.
  a_hd: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(overlap_ratio)) else $error("hold");
  // The input side only fills up behind a waiting result.
  a_fl: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty) else $error("full without result");
endmodule

bind box_pair_overlap_iou bpo_checker #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_chk (
  .clk, .rst, .full, .empty, .pop, .a_holds_b, .b_holds_a,
  .partial_overlap, .degenerate, .overlap_ratio);
`default_nettype wire
